[rtl/hsl_pkg.sv]
// shared constants, codes and the result record for the serial link core
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int DATA_BYTES  = FRAME_BYTES - 2;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int NUM_READ    = 4;
  localparam int FIRST_READ  = 3;

  localparam logic [15:0] START_WORD = 16'hABCD;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  localparam logic [15:0] SEND_INTERVAL_RST    = 16'd100;
  localparam logic [15:0] MIN_RESEND_GAP_RST   = 16'd20;
  localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd500;

  localparam logic [1:0] CFG_SEND_INTERVAL    = 2'd0;
  localparam logic [1:0] CFG_MIN_RESEND_GAP   = 2'd1;
  localparam logic [1:0] CFG_RESPONSE_TIMEOUT = 2'd2;

  localparam logic [2:0] LAST_TX_BYTE = 3'd7;

  typedef enum logic [1:0] {
    FUNC_RX_BYTE   = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_SET_DRIVE = 2'd2,
    FUNC_UNUSED    = 2'd3
  } func_t;

  typedef struct packed {
    logic                          send;
    logic [15:0]                   first_drive;
    logic [15:0]                   second_drive;
    logic                          good;
    logic                          bad;
    logic                          online;
    logic [NUM_READ-1:0][15:0]     readings;
  } result_rec_t;

endpackage

[rtl/hsl_link_ctrl.sv]
// link state: frame assembly, checksum, tick counters, drive hold and config registers
`timescale 1ns / 1ps
module hsl_link_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_fire,
  input  logic [1:0]          func,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         first_drive,
  input  logic [15:0]         second_drive,
  input  logic                cfg_fire,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output hsl_pkg::result_rec_t rec
);
  import hsl_pkg::*;

  logic [15:0]                send_interval_r, min_resend_gap_r, response_timeout_r;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [7:0]                 prev_r, prev_nxt;
  logic [7:0]                 got_lo_r, got_lo_nxt;
  logic [15:0]                xor_r, xor_nxt;
  logic                       online_r, online_nxt;
  logic [15:0]                tss_r, tss_nxt;
  logic [15:0]                tsr_r, tsr_nxt;
  logic [15:0]                held_a_r, held_a_nxt;
  logic [15:0]                held_c_r, held_c_nxt;
  logic [NUM_READ-1:0][15:0]  read_r, read_nxt;
  logic [NUM_READ-1:0][15:0]  pend_r, pend_nxt;
  logic [15:0]                start_chk;
  logic [15:0]                tss_inc, tsr_inc;
  logic                       good, bad, send;

  always_comb begin
    fill_nxt   = fill_r;
    prev_nxt   = prev_r;
    got_lo_nxt = got_lo_r;
    xor_nxt    = xor_r;
    online_nxt = online_r;
    tss_nxt    = tss_r;
    tsr_nxt    = tsr_r;
    held_a_nxt = held_a_r;
    held_c_nxt = held_c_r;
    read_nxt   = read_r;
    pend_nxt   = pend_r;
    good       = 1'b0;
    bad        = 1'b0;
    send       = 1'b0;
    start_chk  = {rx_byte, prev_r};
    tss_inc    = (tss_r < CNT_MAX) ? tss_r + 16'd1 : tss_r;
    tsr_inc    = (tsr_r < CNT_MAX) ? tsr_r + 16'd1 : tsr_r;
    if (item_fire) begin
      case (func_t'(func))
        FUNC_RX_BYTE: begin
          if (start_chk == START_WORD) begin
            fill_nxt = FILL_W'(2);
            xor_nxt  = START_WORD;
            pend_nxt = '0;
          end else if (fill_r >= FILL_W'(2) && fill_r < FILL_W'(FRAME_BYTES)) begin
            fill_nxt = fill_r + FILL_W'(1);
            if (fill_r < FILL_W'(DATA_BYTES)) begin
              if (fill_r[0]) begin
                xor_nxt[15:8] = xor_r[15:8] ^ rx_byte;
              end else begin
                xor_nxt[7:0] = xor_r[7:0] ^ rx_byte;
              end
              for (int j = 0; j < NUM_READ; j++) begin
                if (int'(fill_r[FILL_W-1:1]) == FIRST_READ + j) begin
                  if (fill_r[0]) begin
                    pend_nxt[j][15:8] = rx_byte;
                  end else begin
                    pend_nxt[j][7:0] = rx_byte;
                  end
                end
              end
            end else if (fill_r == FILL_W'(DATA_BYTES)) begin
              got_lo_nxt = rx_byte;
            end else begin
              fill_nxt = '0;
              if ({rx_byte, got_lo_r} == xor_r) begin
                good = 1'b1;
                for (int j = 0; j < NUM_READ; j++) begin
                  if (2 * (FIRST_READ + j) + 2 < FRAME_BYTES) begin
                    read_nxt[j] = pend_r[j];
                  end
                end
                tsr_nxt    = '0;
                online_nxt = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
          end
          prev_nxt = rx_byte;
          if (online_nxt && tsr_nxt > response_timeout_r) begin
            online_nxt = 1'b0;
          end
        end
        FUNC_TICK: begin
          tss_nxt = tss_inc;
          tsr_nxt = tsr_inc;
          if (online_r && tss_inc > send_interval_r) begin
            send    = 1'b1;
            tss_nxt = '0;
          end
          if (online_nxt && tsr_nxt > response_timeout_r) begin
            online_nxt = 1'b0;
          end
        end
        FUNC_SET_DRIVE: begin
          if (first_drive != held_a_r || second_drive != held_c_r) begin
            held_a_nxt = first_drive;
            held_c_nxt = second_drive;
            if (tss_r > min_resend_gap_r) begin
              tss_nxt = send_interval_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rec.send         = send;
    rec.first_drive  = held_a_r;
    rec.second_drive = held_c_r;
    rec.good         = good;
    rec.bad          = bad;
    rec.online       = online_nxt;
    rec.readings     = read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_interval_r    <= SEND_INTERVAL_RST;
      min_resend_gap_r   <= MIN_RESEND_GAP_RST;
      response_timeout_r <= RESPONSE_TIMEOUT_RST;
      fill_r             <= '0;
      prev_r             <= '0;
      online_r           <= 1'b0;
      tss_r              <= '0;
      tsr_r              <= '0;
      held_a_r           <= '0;
      held_c_r           <= '0;
      read_r             <= '0;
    end else begin
      fill_r   <= fill_nxt;
      prev_r   <= prev_nxt;
      online_r <= online_nxt;
      tss_r    <= tss_nxt;
      tsr_r    <= tsr_nxt;
      held_a_r <= held_a_nxt;
      held_c_r <= held_c_nxt;
      read_r   <= read_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_SEND_INTERVAL:    send_interval_r    <= cfg_data;
          CFG_MIN_RESEND_GAP:   min_resend_gap_r   <= cfg_data;
          CFG_RESPONSE_TIMEOUT: response_timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // assembly scratch, only read after being written since a start word
  always_ff @(posedge clk) begin
    got_lo_r <= got_lo_nxt;
    xor_r    <= xor_nxt;
    pend_r   <= pend_nxt;
  end

endmodule

[rtl/hsl_out_queue.sv]
// two-entry result queue with command frame byte serialiser
`timescale 1ns / 1ps
module hsl_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hsl_pkg::result_rec_t push_rec,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [7:0]           out_tx_byte,
  output logic                 out_last_of_run,
  output logic                 out_frame_good,
  output logic                 out_frame_bad,
  output logic                 out_link_online,
  output logic signed [15:0]   out_right_speed,
  output logic signed [15:0]   out_left_speed,
  output logic signed [15:0]   out_battery_voltage,
  output logic signed [15:0]   out_board_temp
);
  import hsl_pkg::*;

  result_rec_t       q_r [2];
  result_rec_t       head;
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;
  logic [2:0]        byte_cnt_r;
  logic [15:0]       word;
  logic              last, out_fire, pop;

  assign head      = q_r[rd_ptr_r];
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign last      = !head.send || (byte_cnt_r == LAST_TX_BYTE);
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && last;

  always_comb begin
    case (byte_cnt_r[2:1])
      2'd0:    word = START_WORD;
      2'd1:    word = head.first_drive;
      2'd2:    word = head.second_drive;
      default: word = START_WORD ^ head.first_drive ^ head.second_drive;
    endcase
  end

  assign out_kind            = head.send;
  assign out_tx_byte         = head.send ? (byte_cnt_r[0] ? word[15:8] : word[7:0]) : 8'd0;
  assign out_last_of_run     = last;
  assign out_frame_good      = head.good;
  assign out_frame_bad       = head.bad;
  assign out_link_online     = head.online;
  assign out_right_speed     = $signed(head.readings[0]);
  assign out_left_speed      = $signed(head.readings[1]);
  assign out_battery_voltage = $signed(head.readings[2]);
  assign out_board_temp      = $signed(head.readings[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      count_r    <= 2'd0;
      byte_cnt_r <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r   <= ~rd_ptr_r;
        byte_cnt_r <= 3'd0;
      end else if (out_fire) begin
        byte_cnt_r <= byte_cnt_r + 3'd1;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/hoverboard_serial_link_core.sv]
// top level of the motor board serial link: state update and result queue
// an item's results enter the result queue register as it is accepted
// throughput: one item per cycle if the queue has room; a send item is 8 bytes
// a two-entry result queue lets items enter while earlier results wait
// reset: synchronous active-low rst_n clears link state, counters and the queue
// and loads the register defaults; both ready outputs stay low while it is held
`timescale 1ns / 1ps
module hoverboard_serial_link_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_rx_byte,
  input  logic signed [15:0] in_first_drive,
  input  logic signed [15:0] in_second_drive,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_of_run,
  output logic               out_frame_good,
  output logic               out_frame_bad,
  output logic               out_link_online,
  output logic signed [15:0] out_right_speed,
  output logic signed [15:0] out_left_speed,
  output logic signed [15:0] out_battery_voltage,
  output logic signed [15:0] out_board_temp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import hsl_pkg::*;

  result_rec_t rec;
  logic        full;
  logic        in_fire;

  assign in_ready  = rst_n && !full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = rst_n;

  hsl_link_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_fire    (in_fire),
    .func         (in_func),
    .rx_byte      (in_rx_byte),
    .first_drive  (in_first_drive),
    .second_drive (in_second_drive),
    .cfg_fire     (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rec          (rec)
  );

  hsl_out_queue u_queue (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (in_fire),
    .push_rec            (rec),
    .full                (full),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_run     (out_last_of_run),
    .out_frame_good      (out_frame_good),
    .out_frame_bad       (out_frame_bad),
    .out_link_online     (out_link_online),
    .out_right_speed     (out_right_speed),
    .out_left_speed      (out_left_speed),
    .out_battery_voltage (out_battery_voltage),
    .out_board_temp      (out_board_temp)
  );

endmodule

[tb/sv/tb_hoverboard_serial_link_core.sv]
// self-checking testbench for the motor board serial link core
`timescale 1ns / 1ps
module tb_hoverboard_serial_link_core;
  import hsl_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SOAK_TICKS  = 8;

  localparam logic [1:0] CHECK_MODEL = 2'd0;
  localparam logic [1:0] CHECK_IDLE  = 2'd1;
  localparam logic [1:0] CHECK_FRAME = 2'd2;

  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  localparam logic [15:0] DIR_RIGHT = 16'h7FFF;
  localparam logic [15:0] DIR_LEFT  = 16'h8000;
  localparam logic [15:0] DIR_VOLT  = 16'h0001;
  localparam logic [15:0] DIR_TEMP  = 16'hFFFF;

  // columns: check, func, rx byte, first drive, second drive
  localparam int DIRECTED_ROWS = 24;
  localparam logic [43:0] DIRECTED [DIRECTED_ROWS] = '{
    {CHECK_IDLE,  FUNC_UNUSED,    8'h00, 16'hFFFF, 16'hFFFF},
    {CHECK_IDLE,  FUNC_TICK,      8'h00, 16'h0000, 16'h0000},
    {CHECK_IDLE,  FUNC_SET_DRIVE, 8'h00, 16'h8000, 16'h7FFF},
    {CHECK_IDLE,  FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hCD, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hAB, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h00, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h00, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h7F, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h00, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h80, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h01, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h00, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'hFF, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h34, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h12, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_RX_BYTE,   8'h07, 16'h0000, 16'h0000},
    {CHECK_FRAME, FUNC_RX_BYTE,   8'h46, 16'h0000, 16'h0000},
    {CHECK_MODEL, FUNC_SET_DRIVE, 8'h00, 16'h7FFF, 16'h8000},
    {CHECK_MODEL, FUNC_TICK,      8'h00, 16'h0000, 16'h0000}
  };

  typedef struct packed {
    logic                  kind;
    logic [7:0]            tx;
    logic                  last;
    logic                  good;
    logic                  bad;
    logic                  online;
    logic [3:0][15:0]      readings;
  } link_result_t;

  typedef struct {
    func_t       func;
    logic [7:0]  rx;
    logic [15:0] first;
    logic [15:0] second;
    logic [1:0]  check;
  } link_stim_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_UNUSED;
  logic [7:0]         in_rx_byte = 8'h00;
  logic signed [15:0] in_first_drive = 16'sd0;
  logic signed [15:0] in_second_drive = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [7:0]         out_tx_byte;
  logic               out_last_of_run;
  logic               out_frame_good;
  logic               out_frame_bad;
  logic               out_link_online;
  logic signed [15:0] out_right_speed;
  logic signed [15:0] out_left_speed;
  logic signed [15:0] out_battery_voltage;
  logic signed [15:0] out_board_temp;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_SEND_INTERVAL;
  logic [15:0]        cfg_data = 16'h0000;

  hoverboard_serial_link_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_rx_byte          (in_rx_byte),
    .in_first_drive      (in_first_drive),
    .in_second_drive     (in_second_drive),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_run     (out_last_of_run),
    .out_frame_good      (out_frame_good),
    .out_frame_bad       (out_frame_bad),
    .out_link_online     (out_link_online),
    .out_right_speed     (out_right_speed),
    .out_left_speed      (out_left_speed),
    .out_battery_voltage (out_battery_voltage),
    .out_board_temp      (out_board_temp),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // link state as the block should hold it
  logic [15:0]       reg_send_interval;
  logic [15:0]       reg_min_gap;
  logic [15:0]       reg_timeout;
  logic [7:0]        rx_frame [FRAME_BYTES];
  logic [FILL_W-1:0] fill_count;
  logic [7:0]        last_rx;
  logic              link_up;
  logic [15:0]       since_send;
  logic [15:0]       since_reply;
  logic [15:0]       held_first;
  logic [15:0]       held_second;
  logic [3:0][15:0]  latched_read;

  link_result_t pending_link_results [$];
  link_stim_t   accepted_stim_q [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int good_seen = 0;
  int bad_seen = 0;
  int tx_bytes_seen = 0;
  int phases_run = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  logic [7:0] frame_buf [FRAME_BYTES];
  logic [15:0] last_first = 16'h0000;
  logic [15:0] last_second = 16'h0000;

  function automatic void reset_link_state();
    reg_send_interval = SEND_INTERVAL_RST;
    reg_min_gap       = MIN_RESEND_GAP_RST;
    reg_timeout       = RESPONSE_TIMEOUT_RST;
    foreach (rx_frame[i]) rx_frame[i] = 8'h00;
    fill_count   = '0;
    last_rx      = 8'h00;
    link_up      = 1'b0;
    since_send   = 16'h0000;
    since_reply  = 16'h0000;
    held_first   = 16'h0000;
    held_second  = 16'h0000;
    latched_read = '0;
  endfunction

  function automatic link_result_t link_status(logic kind, logic [7:0] tx, logic last,
                                               logic good, logic bad);
    link_result_t r;
    r.kind     = kind;
    r.tx       = tx;
    r.last     = last;
    r.good     = good;
    r.bad      = bad;
    r.online   = link_up;
    r.readings = latched_read;
    return r;
  endfunction

  function automatic link_result_t fixed_status(logic [1:0] check);
    link_result_t r;
    r = '0;
    r.last = 1'b1;
    if (check == CHECK_FRAME) begin
      r.good     = 1'b1;
      r.online   = 1'b1;
      r.readings = {DIR_TEMP, DIR_VOLT, DIR_LEFT, DIR_RIGHT};
    end
    return r;
  endfunction

  // bytes beyond the data area read as zero
  function automatic logic [15:0] frame_word(int k);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (2 * k + 2 < FRAME_BYTES) ? rx_frame[2 * k] : 8'h00;
    hi = (2 * k + 3 < FRAME_BYTES) ? rx_frame[2 * k + 1] : 8'h00;
    return {hi, lo};
  endfunction

  function automatic bit close_frame();
    logic [15:0] x;
    logic [15:0] got;
    bit          ok;
    x  = 16'h0000;
    ok = 1'b0;
    for (int k = 0; 2 * k + 2 < FRAME_BYTES; k++) x ^= frame_word(k);
    got = {rx_frame[FRAME_BYTES - 1], rx_frame[FRAME_BYTES - 2]};
    if (x == got && frame_word(0) == START_WORD) begin
      for (int i = 0; i < NUM_READ; i++)
        if (2 * (FIRST_READ + i) + 2 < FRAME_BYTES)
          latched_read[i] = frame_word(FIRST_READ + i);
      since_reply = 16'h0000;
      link_up     = 1'b1;
      ok          = 1'b1;
    end
    fill_count = '0;
    return ok;
  endfunction

  function automatic void apply_timeout();
    if (link_up && since_reply > reg_timeout) link_up = 1'b0;
  endfunction

  function automatic void advance_link(link_stim_t s);
    logic [15:0] sw;
    logic [15:0] cmd [4];
    logic [7:0]  cmd_byte;
    logic        good;
    logic        bad;
    good = 1'b0;
    bad  = 1'b0;
    case (s.func)
      FUNC_RX_BYTE: begin
        sw = {s.rx, last_rx};
        if (sw == START_WORD) begin
          rx_frame[0] = last_rx;
          rx_frame[1] = s.rx;
          fill_count  = FILL_W'(2);
        end else if (fill_count >= 2 && fill_count < FRAME_BYTES) begin
          rx_frame[fill_count] = s.rx;
          fill_count++;
          if (fill_count == FRAME_BYTES) begin
            if (close_frame()) good = 1'b1;
            else bad = 1'b1;
          end
        end
        last_rx = s.rx;
        apply_timeout();
      end
      FUNC_TICK: begin
        if (since_send < CNT_MAX) since_send++;
        if (since_reply < CNT_MAX) since_reply++;
        if (link_up && since_send > reg_send_interval) begin
          since_send = 16'h0000;
          cmd[0] = START_WORD;
          cmd[1] = held_first;
          cmd[2] = held_second;
          cmd[3] = START_WORD ^ held_first ^ held_second;
          apply_timeout();
          for (int k = 0; k < 8; k++) begin
            cmd_byte = k[0] ? cmd[k >> 1][15:8] : cmd[k >> 1][7:0];
            pending_link_results.push_back(link_status(1'b1, cmd_byte, k == 7, 1'b0, 1'b0));
          end
          return;
        end
        apply_timeout();
      end
      FUNC_SET_DRIVE: begin
        if (s.first != held_first || s.second != held_second) begin
          held_first  = s.first;
          held_second = s.second;
          if (since_send > reg_min_gap) since_send = reg_send_interval;
        end
      end
      default: begin
      end
    endcase
    pending_link_results.push_back(link_status(1'b0, 8'h00, 1'b1, good, bad));
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic compare_result(link_result_t got, link_result_t want);
    if (got.kind !== want.kind) report_mismatch("kind", 16'(got.kind), 16'(want.kind));
    if (got.tx !== want.tx) report_mismatch("tx_byte", 16'(got.tx), 16'(want.tx));
    if (got.last !== want.last)
      report_mismatch("last_of_run", 16'(got.last), 16'(want.last));
    if (got.good !== want.good)
      report_mismatch("frame_good", 16'(got.good), 16'(want.good));
    if (got.bad !== want.bad) report_mismatch("frame_bad", 16'(got.bad), 16'(want.bad));
    if (got.online !== want.online)
      report_mismatch("link_online", 16'(got.online), 16'(want.online));
    if (got.readings[0] !== want.readings[0])
      report_mismatch("right_speed", got.readings[0], want.readings[0]);
    if (got.readings[1] !== want.readings[1])
      report_mismatch("left_speed", got.readings[1], want.readings[1]);
    if (got.readings[2] !== want.readings[2])
      report_mismatch("battery_voltage", got.readings[2], want.readings[2]);
    if (got.readings[3] !== want.readings[3])
      report_mismatch("board_temp", got.readings[3], want.readings[3]);
  endtask

  // accepted items and register writes feed the prediction
  link_stim_t   taken;
  link_result_t typed_res;
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      taken = accepted_stim_q.pop_front();
      advance_link(taken);
      if (taken.check != CHECK_MODEL) begin
        typed_res = fixed_status(taken.check);
        void'(pending_link_results.pop_back());
        pending_link_results.push_back(typed_res);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEND_INTERVAL:    reg_send_interval = cfg_data;
        CFG_MIN_RESEND_GAP:   reg_min_gap = cfg_data;
        CFG_RESPONSE_TIMEOUT: reg_timeout = cfg_data;
        default: begin
        end
      endcase
    end
  end

  link_result_t got_res;
  link_result_t want_res;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res.kind        = out_kind;
      got_res.tx          = out_tx_byte;
      got_res.last        = out_last_of_run;
      got_res.good        = out_frame_good;
      got_res.bad         = out_frame_bad;
      got_res.online      = out_link_online;
      got_res.readings[0] = out_right_speed;
      got_res.readings[1] = out_left_speed;
      got_res.readings[2] = out_battery_voltage;
      got_res.readings[3] = out_board_temp;
      results_seen++;
      if (out_frame_good === 1'b1) good_seen++;
      if (out_frame_bad === 1'b1) bad_seen++;
      if (out_kind === 1'b1) tx_bytes_seen++;
      if (pending_link_results.size() == 0) begin
        report_mismatch("unexpected result", {15'd0, out_kind}, 16'h0000);
      end else begin
        want_res = pending_link_results.pop_front();
        compare_result(got_res, want_res);
      end
    end
  end

  // receiver stall pattern
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(8, 64);
    end
    rx_mode_left--;
    rx_phase++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_phase % 3 == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding", QUIET_LIMIT,
               pending_link_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic link_stim_t make_stim(func_t f, logic [7:0] rx, logic [15:0] a,
                                           logic [15:0] b);
    link_stim_t s;
    s.func   = f;
    s.rx     = rx;
    s.first  = a;
    s.second = b;
    s.check  = CHECK_MODEL;
    return s;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drive_item(link_stim_t s);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_func         <= s.func;
    in_rx_byte      <= s.rx;
    in_first_drive  <= s.first;
    in_second_drive <= s.second;
    accepted_stim_q.push_back(s);
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drive_tick();
    drive_item(make_stim(FUNC_TICK, 8'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic drive_byte(logic [7:0] b);
    drive_item(make_stim(FUNC_RX_BYTE, b, 16'($urandom), 16'($urandom)));
  endtask

  task automatic drive_frame_span(int lo, int hi);
    for (int i = lo; i <= hi; i++) drive_byte(frame_buf[i]);
  endtask

  task automatic fill_frame_buf(bit corrupt);
    logic [15:0] w;
    logic [15:0] x;
    frame_buf[0] = START_WORD[7:0];
    frame_buf[1] = START_WORD[15:8];
    x = START_WORD;
    for (int k = 1; 2 * k + 2 < FRAME_BYTES; k++) begin
      w = pick_word();
      frame_buf[2 * k]     = w[7:0];
      frame_buf[2 * k + 1] = w[15:8];
      x ^= w;
    end
    frame_buf[FRAME_BYTES - 2] = x[7:0];
    frame_buf[FRAME_BYTES - 1] = x[15:8];
    if (corrupt)
      frame_buf[$urandom_range(2, FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(0, 7));
  endtask

  // wait until the block has drained, then a little longer
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_link_results.size() != 0 || accepted_stim_q.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] si, logic [15:0] mg, logic [15:0] to);
    write_reg(CFG_SEND_INTERVAL, si);
    write_reg(CFG_MIN_RESEND_GAP, mg);
    write_reg(CFG_RESPONSE_TIMEOUT, to);
    write_reg(CFG_UNUSED_INDEX, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(int count);
    int stop;
    int pick;
    int n;
    logic [7:0] b;
    stop = items_sent + count;
    gaps_on = ($urandom_range(0, 3) != 0);
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        fill_frame_buf(1'b0);
        drive_frame_span(0, FRAME_BYTES - 1);
      end else if (pick < 40) begin
        fill_frame_buf(1'b1);
        drive_frame_span(0, FRAME_BYTES - 1);
      end else if (pick < 45) begin
        // frame of random length, often cut short by a fresh start word
        fill_frame_buf(1'b0);
        drive_frame_span(0, $urandom_range(2, FRAME_BYTES - 1));
        fill_frame_buf($urandom_range(0, 3) == 0);
        drive_frame_span(0, FRAME_BYTES - 1);
      end else if (pick < 49) begin
        // start word lands on the final byte slot
        fill_frame_buf(1'b0);
        drive_frame_span(0, FRAME_BYTES - 3);
        drive_byte(START_WORD[7:0]);
        drive_byte(START_WORD[15:8]);
        fill_frame_buf(1'b0);
        drive_frame_span(2, FRAME_BYTES - 1);
      end else if (pick < 72) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
        repeat (n) drive_tick();
      end else if (pick < 87) begin
        if ($urandom_range(0, 3) != 0) begin
          last_first  = pick_word();
          last_second = pick_word();
        end
        drive_item(make_stim(FUNC_SET_DRIVE, 8'($urandom), last_first, last_second));
      end else if (pick < 95) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: b = START_WORD[7:0];
            1: b = START_WORD[15:8];
            default: b = 8'($urandom);
          endcase
          drive_byte(b);
        end
      end else begin
        drive_item(make_stim(FUNC_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom)));
      end
    end
  endtask

  task automatic run_phase(logic [15:0] si, logic [15:0] mg, logic [15:0] to);
    settle();
    configure(si, mg, to);
    phases_run++;
    run_traffic(42);
  endtask

  logic [43:0] row;
  link_stim_t  dir_stim;
  initial begin
    reset_link_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      dir_stim.check  = row[43:42];
      dir_stim.func   = func_t'(row[41:40]);
      dir_stim.rx     = row[39:32];
      dir_stim.first  = row[31:16];
      dir_stim.second = row[15:0];
      drive_item(dir_stim);
    end

    run_phase(SEND_INTERVAL_RST, MIN_RESEND_GAP_RST, RESPONSE_TIMEOUT_RST);
    run_phase(16'd0, 16'd0, 16'd0);
    run_phase(16'd3, 16'd1, 16'd40);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(16'd1, 16'd0, 16'd12);
    run_phase(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
              16'($urandom_range(0, 200)));
    run_phase(16'd10, 16'd4, 16'd200);

    // short tick run with every register at its ceiling, then ticks with a lowered send interval and timeout
    settle();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    phases_run++;
    gaps_on = 1'b0;
    fill_frame_buf(1'b0);
    drive_frame_span(0, FRAME_BYTES - 1);
    repeat (SOAK_TICKS) drive_tick();
    drive_item(make_stim(FUNC_SET_DRIVE, 8'h00, ~held_first, held_second));
    settle();
    write_reg(CFG_SEND_INTERVAL, 16'd100);
    write_reg(CFG_RESPONSE_TIMEOUT, 16'hFFFE);
    cfg_valid <= 1'b0;
    repeat (3) drive_tick();

    settle();
    repeat (16) @(posedge clk);
    $display("covered %0d items over %0d register settings plus directed rows, %0d results",
             items_sent, phases_run, results_seen);
    $display("frames accepted %0d, frames rejected %0d, command frames sent %0d",
             good_seen, bad_seen, tx_bytes_seen / 8);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
